// ===== hw/rtl/svf_pkg.sv =====
`default_nettype none

package svf_pkg;

  localparam int POS_FRAC_BITS_DEF  = 8;
  localparam int ZOOM_FRAC_BITS_DEF = 8;
  localparam int WORLD_INT_BITS_DEF = 15;

  localparam int WORLD_W     = 15;
  localparam int SCREEN_W    = 12;
  localparam int GAIN_W      = 16;
  localparam int DT_W        = 16;
  localparam int GDT_W       = GAIN_W + DT_W;
  localparam int STEP_SHIFT  = 24;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  localparam logic [WORLD_W-1:0]  WORLD_WIDTH_RST   = 15'd3200;
  localparam logic [WORLD_W-1:0]  WORLD_HEIGHT_RST  = 15'd1920;
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd1280;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd720;
  localparam logic [GAIN_W-1:0]   FOLLOW_GAIN_RST   = 16'd1280;

  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_GAIN   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GDT,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_DW,
    ST_DH,
    ST_FIN
  } svf_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smoothed_viewport_follow.sv =====
// channel | direction | handshake             | payload
// s       | in        | s_tvalid / s_tready   | s_tdata, s_tuser (mode)
// m       | out       | m_tvalid / m_tready   | m_tdata
// cfg     | in        | cfg_we, no wait       | cfg_index, cfg_data
//
// A tick runs four passes of the bit-serial multiplier and two of the restoring
// divider, one bit per cycle. A recenter skips both and goes straight to the result.
// One item is in flight at a time; s_tready is high only while idle.
// The result sits in an output register; a finished item holds in its last
// state while that register is still full. Reset is synchronous: registers
// return to defaults, center to zero, zoom to 1.0.
`default_nettype none

module smoothed_viewport_follow #(
  parameter int POS_FRAC_BITS  = svf_pkg::POS_FRAC_BITS_DEF,
  parameter int ZOOM_FRAC_BITS = svf_pkg::ZOOM_FRAC_BITS_DEF,
  parameter int WORLD_INT_BITS = svf_pkg::WORLD_INT_BITS_DEF,
  localparam int POS_W   = 1 + WORLD_INT_BITS + POS_FRAC_BITS,
  localparam int ZOOM_W  = 2 + ZOOM_FRAC_BITS,
  localparam int IN_BITS = 2 * POS_W + ZOOM_W + svf_pkg::DT_W,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * POS_W + ZOOM_W,
  localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // aim_x, aim_y, zoom_request, time_step, zero fill
  input  wire logic [IN_W-1:0]                s_tdata,
  // mode
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // view_x, view_y, view_zoom, zero fill
  output logic [OUT_W-1:0]                    m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [svf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [svf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MAG_W   = ((POS_W > ZOOM_W) ? POS_W : ZOOM_W) + 1;
  localparam int DIFF_W  = MAG_W + 1;
  localparam int PROD_W  = svf_pkg::GDT_W + MAG_W;
  localparam int STEP_W  = PROD_W - svf_pkg::STEP_SHIFT;
  localparam int SUM_W   = STEP_W + 2;
  localparam int NUM_W   = svf_pkg::SCREEN_W + POS_FRAC_BITS + ZOOM_FRAC_BITS;
  localparam int DEN_W   = ZOOM_W + 1;
  localparam int HALF_W  = svf_pkg::SCREEN_W + POS_FRAC_BITS;
  localparam int WPIX_W  = svf_pkg::WORLD_W + POS_FRAC_BITS;
  localparam int FIT_A   = (POS_W > WPIX_W) ? POS_W : WPIX_W;
  localparam int FIT_W   = ((FIT_A > HALF_W) ? FIT_A : HALF_W) + 2;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [ZOOM_W-1:0] ZOOM_MIN = ZOOM_W'(1) << (ZOOM_FRAC_BITS - 1);
  localparam logic [ZOOM_W-1:0] ZOOM_ONE = ZOOM_W'(1) << ZOOM_FRAC_BITS;
  localparam logic [ZOOM_W-1:0] ZOOM_MAX = ZOOM_W'(2) << ZOOM_FRAC_BITS;

  svf_pkg::svf_state_t state, state_next, prev_state;

  logic [svf_pkg::WORLD_W-1:0]  world_width, world_height;
  logic [svf_pkg::SCREEN_W-1:0] screen_width, screen_height;
  logic [svf_pkg::GAIN_W-1:0]   follow_gain;

  logic signed [POS_W-1:0] center_x, center_y;
  logic [ZOOM_W-1:0]       zoom_level;

  logic                    mode_q;
  logic signed [POS_W-1:0] tx_q, ty_q;
  logic [ZOOM_W-1:0]       zr_q;
  logic [svf_pkg::DT_W-1:0] dt_q;
  logic [svf_pkg::GDT_W-1:0] gdt_q;
  logic signed [POS_W-1:0] nx_q, ny_q;
  logic [ZOOM_W-1:0]       nz_q;
  logic [HALF_W-1:0]       hw_q, hh_q;

  logic [ZOOM_W-1:0]       zr_raw, zr_clamp;
  logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;

  logic                        mul_start, mul_done;
  logic [svf_pkg::GDT_W-1:0]   mul_a;
  logic [MAG_W-1:0]            mul_b;
  logic [PROD_W-1:0]           mul_prod;
  logic signed [SUM_W-1:0]     step_s;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num;
  logic [NUM_W-1:0]   div_quo;

  logic                    fin_load;
  logic signed [POS_W-1:0] new_x, new_y;
  logic [ZOOM_W-1:0]       new_z;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] t;
    t = d[DIFF_W-1] ? -d : d;
    return t[MAG_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > SUM_W'(POS_MAX)) r = POS_MAX;
    else if (v < SUM_W'(POS_MIN)) r = POS_MIN;
    else r = v[POS_W-1:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] fit_axis(
    input logic signed [POS_W-1:0]   c,
    input logic [svf_pkg::WORLD_W-1:0] world,
    input logic [HALF_W-1:0]         half
  );
    logic signed [FIT_W-1:0] cf, hf, wf, r;
    logic signed [POS_W-1:0] o;
    cf = FIT_W'(c);
    hf = $signed(FIT_W'(half));
    wf = $signed(FIT_W'({world, {POS_FRAC_BITS{1'b0}}}));
    r  = cf;
    if (cf < hf) r = hf;
    if (r + hf > wf) r = wf - hf;
    if (r > FIT_W'(POS_MAX)) o = POS_MAX;
    else if (r < FIT_W'(POS_MIN)) o = POS_MIN;
    else o = r[POS_W-1:0];
    return o;
  endfunction

  function automatic logic signed [POS_W-1:0] mid_pos(input logic [svf_pkg::WORLD_W-1:0] world);
    logic [FIT_W-1:0]        v;
    logic signed [POS_W-1:0] o;
    v = FIT_W'({world, {(POS_FRAC_BITS-1){1'b0}}});
    if (v > $unsigned(FIT_W'(POS_MAX))) o = POS_MAX;
    else o = $signed(v[POS_W-1:0]);
    return o;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      world_width   <= svf_pkg::WORLD_WIDTH_RST;
      world_height  <= svf_pkg::WORLD_HEIGHT_RST;
      screen_width  <= svf_pkg::SCREEN_WIDTH_RST;
      screen_height <= svf_pkg::SCREEN_HEIGHT_RST;
      follow_gain   <= svf_pkg::FOLLOW_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        svf_pkg::CFG_WORLD_WIDTH:   world_width   <= cfg_data[svf_pkg::WORLD_W-1:0];
        svf_pkg::CFG_WORLD_HEIGHT:  world_height  <= cfg_data[svf_pkg::WORLD_W-1:0];
        svf_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[svf_pkg::SCREEN_W-1:0];
        svf_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[svf_pkg::SCREEN_W-1:0];
        svf_pkg::CFG_FOLLOW_GAIN:   follow_gain   <= cfg_data[svf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  assign zr_raw   = s_tdata[2*POS_W +: ZOOM_W];
  assign zr_clamp = (zr_raw < ZOOM_MIN) ? ZOOM_MIN : ((zr_raw > ZOOM_MAX) ? ZOOM_MAX : zr_raw);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode_q <= s_tuser;
      tx_q   <= $signed(s_tdata[POS_W-1:0]);
      ty_q   <= $signed(s_tdata[POS_W +: POS_W]);
      zr_q   <= zr_clamp;
      dt_q   <= s_tdata[2*POS_W+ZOOM_W +: svf_pkg::DT_W];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      svf_pkg::ST_IDLE: if (s_tvalid) state_next = s_tuser ? svf_pkg::ST_FIN : svf_pkg::ST_GDT;
      svf_pkg::ST_GDT:  if (mul_done) state_next = svf_pkg::ST_MX;
      svf_pkg::ST_MX:   if (mul_done) state_next = svf_pkg::ST_MY;
      svf_pkg::ST_MY:   if (mul_done) state_next = svf_pkg::ST_MZ;
      svf_pkg::ST_MZ:   if (mul_done) state_next = svf_pkg::ST_DW;
      svf_pkg::ST_DW:   if (div_done) state_next = svf_pkg::ST_DH;
      svf_pkg::ST_DH:   if (div_done) state_next = svf_pkg::ST_FIN;
      svf_pkg::ST_FIN:  if (!m_tvalid || m_tready) state_next = svf_pkg::ST_IDLE;
      default:          state_next = svf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    fin_load  = 1'b0;
    case (state)
      svf_pkg::ST_IDLE: s_tready = 1'b1;
      svf_pkg::ST_GDT, svf_pkg::ST_MX, svf_pkg::ST_MY, svf_pkg::ST_MZ:
        mul_start = (prev_state != state);
      svf_pkg::ST_DW, svf_pkg::ST_DH:
        div_start = (prev_state != state);
      svf_pkg::ST_FIN: fin_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= svf_pkg::ST_IDLE;
      prev_state <= svf_pkg::ST_IDLE;
    end else begin
      state      <= state_next;
      prev_state <= state;
    end
  end

  // multiplier operands
  assign diff_x = DIFF_W'(tx_q) - DIFF_W'(center_x);
  assign diff_y = DIFF_W'(ty_q) - DIFF_W'(center_y);
  assign diff_z = $signed(DIFF_W'(zr_q)) - $signed(DIFF_W'(zoom_level));

  always_comb begin
    mul_a = gdt_q;
    mul_b = mag_of(diff_x);
    case (state)
      svf_pkg::ST_GDT: begin
        mul_a = svf_pkg::GDT_W'(follow_gain);
        mul_b = MAG_W'(dt_q);
      end
      svf_pkg::ST_MY: mul_b = mag_of(diff_y);
      svf_pkg::ST_MZ: mul_b = mag_of(diff_z);
      default: ;
    endcase
  end

  svf_mul #(
    .A_W(svf_pkg::GDT_W),
    .B_W(MAG_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign step_s  = $signed(SUM_W'(mul_prod[PROD_W-1:svf_pkg::STEP_SHIFT]));
  assign div_num = {(state == svf_pkg::ST_DH) ? screen_height : screen_width,
                    {(POS_FRAC_BITS + ZOOM_FRAC_BITS){1'b0}}};

  svf_div #(
    .N_W(NUM_W),
    .D_W(DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   ({nz_q, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  // collect step results and half views
  always_ff @(posedge clk) begin
    case (state)
      svf_pkg::ST_GDT: if (mul_done) gdt_q <= mul_prod[svf_pkg::GDT_W-1:0];
      svf_pkg::ST_MX: if (mul_done)
        nx_q <= sat_pos(SUM_W'(center_x) + (diff_x[DIFF_W-1] ? -step_s : step_s));
      svf_pkg::ST_MY: if (mul_done)
        ny_q <= sat_pos(SUM_W'(center_y) + (diff_y[DIFF_W-1] ? -step_s : step_s));
      svf_pkg::ST_MZ: if (mul_done) begin
        if ($signed(SUM_W'(zoom_level)) + (diff_z[DIFF_W-1] ? -step_s : step_s)
            < $signed(SUM_W'(ZOOM_MIN)))
          nz_q <= ZOOM_MIN;
        else if ($signed(SUM_W'(zoom_level)) + (diff_z[DIFF_W-1] ? -step_s : step_s)
                 > $signed(SUM_W'(ZOOM_MAX)))
          nz_q <= ZOOM_MAX;
        else
          nz_q <= ZOOM_W'(SUM_W'(zoom_level) + (diff_z[DIFF_W-1] ? -step_s : step_s));
      end
      svf_pkg::ST_DW: if (div_done) hw_q <= div_quo[HALF_W-1:0];
      svf_pkg::ST_DH: if (div_done) hh_q <= div_quo[HALF_W-1:0];
      default: ;
    endcase
  end

  // final values
  assign new_x = mode_q ? mid_pos(world_width)  : fit_axis(nx_q, world_width, hw_q);
  assign new_y = mode_q ? mid_pos(world_height) : fit_axis(ny_q, world_height, hh_q);
  assign new_z = mode_q ? ZOOM_ONE : nz_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      zoom_level <= ZOOM_ONE;
      m_tvalid   <= 1'b0;
    end else begin
      if (fin_load) begin
        center_x   <= new_x;
        center_y   <= new_y;
        zoom_level <= new_z;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      m_tdata <= OUT_W'({new_z, new_y, new_x});
    end
  end

  a_zoom_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2*POS_W +: ZOOM_W] >= ZOOM_MIN &&
                  m_tdata[2*POS_W +: ZOOM_W] <= ZOOM_MAX))
    else $error("view zoom out of range");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transaction accepted while busy");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == svf_pkg::ST_GDT || state == svf_pkg::ST_MX ||
                  state == svf_pkg::ST_MY || state == svf_pkg::ST_MZ))
    else $error("multiplier finished outside a multiply step");

endmodule

`default_nettype wire

// ===== hw/rtl/svf_mul.sv =====
`default_nettype none

module svf_mul #(
  parameter int A_W = svf_pkg::GDT_W,
  parameter int B_W = 25
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    done,
  output logic [A_W+B_W-1:0]      prod
);

  localparam int CNT_W = $clog2(B_W);

  logic [A_W+B_W-1:0] acc;
  logic [A_W-1:0]     a_reg;
  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [A_W:0]       sum;

  // add multiplicand on the low multiplier bit, then shift the whole word right
  assign sum  = {1'b0, acc[A_W+B_W-1:B_W]} + (acc[0] ? {1'b0, a_reg} : {(A_W+1){1'b0}});
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {{A_W{1'b0}}, b};
      a_reg <= a;
    end else if (busy) begin
      acc <= {sum, acc[B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/svf_div.sv =====
`default_nettype none

module svf_div #(
  parameter int N_W = 28,
  parameter int D_W = 11
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] num,
  input  wire logic [D_W-1:0] den,
  output logic                done,
  output logic [N_W-1:0]      quo
);

  localparam int CNT_W = $clog2(N_W);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   rem_next;
  logic [N_W-1:0]   q;
  logic [D_W-1:0]   d_reg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     trial;
  logic [D_W:0]     diffv;
  logic             ge;

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign trial    = {rem, q[N_W-1]};
  assign diffv    = trial - {1'b0, d_reg};
  assign ge       = trial >= {1'b0, d_reg};
  assign rem_next = ge ? diffv[D_W-1:0] : trial[D_W-1:0];
  assign quo      = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      q     <= num;
      d_reg <= den;
    end else if (busy) begin
      rem <= rem_next;
      q   <= {q[N_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire
